FILE: rtl/gbp_pkg.sv
package gbp_pkg;

    localparam int HISTORY_BITS_DEF = 12;
    localparam int COUNTER_BITS_DEF = 2;
    localparam int THREADS_DEF      = 4;

    localparam int REQ_W  = 3;
    localparam int TID_W  = 2;
    localparam int ADDR_W = 32;
    localparam int SNAP_W = 12;

    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_UNCOND  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BTB_FIX = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SQUASH  = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TID_W-1:0]  thread_id;
        logic [ADDR_W-1:0] br_pc;
        logic              taken;
        logic              squashed;
        logic [SNAP_W-1:0] saved_history;
    } t_in_word;

    typedef struct packed {
        logic              predict_taken;
        logic [SNAP_W-1:0] history_snapshot;
    } t_out_word;

endpackage

FILE: rtl/gbp_ram.sv
module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gbp_hist.sv
module gbp_hist #(
    parameter int THREADS      = gbp_pkg::THREADS_DEF,
    parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [gbp_pkg::TID_W-1:0] i_rd_tid,
    output logic [HISTORY_BITS-1:0]   o_rd_hist,
    input  logic                      i_wr_en,
    input  logic [gbp_pkg::TID_W-1:0] i_wr_tid,
    input  logic [HISTORY_BITS-1:0]   i_wr_hist
);
    import gbp_pkg::*;

    localparam int TIDX_W = (THREADS > 1) ? $clog2(THREADS) : 1;

    logic [HISTORY_BITS-1:0] r_hist [THREADS];

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < THREADS; t++) begin
            if (!i_rst_n) begin
                r_hist[t] <= '0;
            end else if (i_wr_en && (int'(i_wr_tid) == t)) begin
                r_hist[t] <= i_wr_hist;
            end
        end
    end

    // out-of-range thread reads as zero
    always_comb begin
        o_rd_hist = '0;
        if (int'(i_rd_tid) < THREADS) begin
            o_rd_hist = r_hist[TIDX_W'(i_rd_tid)];
        end
    end

endmodule

FILE: rtl/gshare_branch_predictor_top.sv
// gshare branch predictor
// input channel: i_in_valid / o_in_stall carry one request word (lookup,
// unconditional branch, btb miss fix, update, squash) for one thread
// output channel: o_out_valid / i_out_stall return one result word per request:
// prediction and pre-shift thread history for lookups and unconditional branches, else zero
// each request reads the counter memory in the cycle it is accepted and
// finishes in the access state that follows, writing the counter back on
// an update, so one request is in flight at a time
// the result sits in an output register; the next request is accepted
// while that register still waits to be taken
// when the receiver stalls with a result pending, the finished request
// holds in the access state until the output register frees up
// after reset the counter memory is cleared one entry per cycle, all
// 2**HISTORY_BITS entries (4096 by default), with o_in_stall high;
// thread histories clear at once
module gshare_branch_predictor_top #(
    parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF,
    parameter int COUNTER_BITS = gbp_pkg::COUNTER_BITS_DEF,
    parameter int THREADS      = gbp_pkg::THREADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gbp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gbp_pkg::t_out_word o_out_word
);
    import gbp_pkg::*;

    localparam int DEPTH = 1 << HISTORY_BITS;

    t_state                  r_state, n_state;
    logic [HISTORY_BITS-1:0] r_clr_idx, n_clr_idx;
    t_in_word                r_item, n_item;
    logic [HISTORY_BITS-1:0] r_idx, n_idx;
    logic [HISTORY_BITS-1:0] r_h, n_h;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out_word, n_out_word;

    logic                    w_ram_we, w_ram_re;
    logic [HISTORY_BITS-1:0] w_ram_waddr;
    logic [COUNTER_BITS-1:0] w_ram_wdata, w_ctr, w_ctr_next;
    logic [HISTORY_BITS-1:0] w_in_hist, w_in_snap, w_in_idx;
    logic [HISTORY_BITS-1:0] w_snap, w_hist_new;
    logic                    w_hist_we, w_hist_wr, w_upd, w_pred, w_tid_ok;
    t_out_word               w_result;

    gbp_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (DEPTH)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_in_idx),
        .o_rdata (w_ctr)
    );

    gbp_hist #(
        .THREADS      (THREADS),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_tid  (i_in_word.thread_id),
        .o_rd_hist (w_in_hist),
        .i_wr_en   (w_hist_wr),
        .i_wr_tid  (r_item.thread_id),
        .i_wr_hist (w_hist_new)
    );

    // table index at accept
    assign w_in_snap = HISTORY_BITS'(i_in_word.saved_history);
    always_comb begin
        if (i_in_word.req_type == REQ_UPDATE) begin
            w_in_idx = i_in_word.br_pc[HISTORY_BITS-1:0] ^ w_in_snap;
        end else begin
            w_in_idx = i_in_word.br_pc[HISTORY_BITS-1:0] ^ w_in_hist;
        end
    end

    // saturating counter step
    always_comb begin
        w_ctr_next = w_ctr;
        if (r_item.taken) begin
            if (!(&w_ctr)) begin
                w_ctr_next = COUNTER_BITS'(w_ctr + 1'b1);
            end
        end else if (|w_ctr) begin
            w_ctr_next = COUNTER_BITS'(w_ctr - 1'b1);
        end
    end

    // access state: result and history
    assign w_snap   = HISTORY_BITS'(r_item.saved_history);
    assign w_tid_ok = int'(r_item.thread_id) < THREADS;

    always_comb begin
        w_pred     = 1'b0;
        w_result   = '0;
        w_hist_we  = 1'b0;
        w_hist_new = r_h;
        w_upd      = 1'b0;
        if (w_tid_ok) begin
            unique case (r_item.req_type)
                REQ_LOOKUP: begin
                    w_pred     = w_ctr[COUNTER_BITS-1];
                    w_result   = '{predict_taken: w_pred, history_snapshot: SNAP_W'(r_h)};
                    w_hist_we  = 1'b1;
                    w_hist_new = HISTORY_BITS'({r_h, w_pred});
                end
                REQ_UNCOND: begin
                    w_result   = '{predict_taken: 1'b1, history_snapshot: SNAP_W'(r_h)};
                    w_hist_we  = 1'b1;
                    w_hist_new = HISTORY_BITS'({r_h, 1'b1});
                end
                REQ_BTB_FIX: begin
                    w_hist_we  = 1'b1;
                    w_hist_new = r_h & ~HISTORY_BITS'(1);
                end
                REQ_UPDATE: begin
                    w_upd      = 1'b1;
                    w_hist_we  = r_item.squashed;
                    w_hist_new = HISTORY_BITS'({w_snap, r_item.taken});
                end
                REQ_SQUASH: begin
                    w_hist_we  = 1'b1;
                    w_hist_new = w_snap;
                end
                default: begin
                    w_hist_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_h        <= n_h;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_item      = r_item;
        n_idx       = r_idx;
        n_h         = r_h;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_waddr = r_idx;
        w_ram_wdata = w_ctr_next;
        w_hist_wr   = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_idx;
                w_ram_wdata = '0;
                n_clr_idx   = HISTORY_BITS'(r_clr_idx + 1'b1);
                if (&r_clr_idx) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_word;
                    n_idx    = w_in_idx;
                    n_h      = w_in_hist;
                    w_ram_re = 1'b1;
                    n_state  = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = w_result;
                    w_ram_we    = w_upd;
                    w_hist_wr   = w_hist_we;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_accept_to_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_ACCESS))
        else $error("accepted word did not start a table access");

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state != ST_IDLE))
        else $error("counter write outside clear or access");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_ACCESS))
        else $error("result word appeared without an access");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && (&r_clr_idx)) |=> (r_state == ST_IDLE))
        else $error("clearing pass did not end");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_word))
        else $error("pending result word overwritten");

endmodule

FILE: tb/gshare_branch_predictor_checker.sv
module gshare_branch_predictor_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  gbp_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  gbp_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    import gbp_pkg::*;

    localparam int HB = HISTORY_BITS_DEF;
    localparam int CB = COUNTER_BITS_DEF;
    localparam int TH = THREADS_DEF;

    logic [CB-1:0] pattern_counters [0:(1<<HB)-1];
    logic [HB-1:0] thread_history   [0:TH-1];
    t_out_word     expected_results [$];
    int            words_checked;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        words_checked = 0;
    end

    // one request against the predictor state, returns the result word it yields
    function automatic t_out_word run_request(input t_in_word w);
        t_out_word     r;
        logic [HB-1:0] h;
        logic [HB-1:0] snap;
        logic [HB-1:0] idx;
        logic          pred;
        r    = '0;
        snap = HB'(w.saved_history);
        if (int'(w.thread_id) < TH) begin
            h = thread_history[w.thread_id];
            case (w.req_type)
                REQ_LOOKUP: begin
                    idx                = HB'(w.br_pc) ^ h;
                    pred               = pattern_counters[idx][CB-1];
                    r.predict_taken    = pred;
                    r.history_snapshot = SNAP_W'(h);
                    thread_history[w.thread_id] = (h << 1) | HB'(pred);
                end
                REQ_UNCOND: begin
                    r.predict_taken    = 1'b1;
                    r.history_snapshot = SNAP_W'(h);
                    thread_history[w.thread_id] = (h << 1) | HB'(1'b1);
                end
                REQ_BTB_FIX: begin
                    thread_history[w.thread_id] = h & ~HB'(1'b1);
                end
                REQ_UPDATE: begin
                    idx = HB'(w.br_pc) ^ snap;
                    if (w.taken) begin
                        if (pattern_counters[idx] != '1)
                            pattern_counters[idx] = pattern_counters[idx] + 1'b1;
                    end else begin
                        if (pattern_counters[idx] != '0)
                            pattern_counters[idx] = pattern_counters[idx] - 1'b1;
                    end
                    if (w.squashed)
                        thread_history[w.thread_id] = (snap << 1) | HB'(w.taken);
                end
                REQ_SQUASH: begin
                    thread_history[w.thread_id] = snap;
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int a = 0; a < (1 << HB); a++)
                pattern_counters[a] = '0;
            for (int t = 0; t < TH; t++)
                thread_history[t] = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word: predict_taken %0b history_snapshot %03h",
                                 i_out_word.predict_taken, i_out_word.history_snapshot);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_word.predict_taken !== want.predict_taken ||
                        i_out_word.history_snapshot !== want.history_snapshot) begin
                        if (o_fail_count < 10)
                            $display({"mismatch on word %0d: predict_taken exp %0b got %0b, ",
                                      "history_snapshot exp %03h got %03h"},
                                     words_checked, want.predict_taken,
                                     i_out_word.predict_taken, want.history_snapshot,
                                     i_out_word.history_snapshot);
                        o_fail_count++;
                    end
                    words_checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(run_request(i_in_word));
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/gshare_branch_predictor_top_tb.sv
module gshare_branch_predictor_top_tb;
    import gbp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 600;
    localparam int POOL_DEPTH   = 32;

    typedef struct {
        logic [TID_W-1:0]  tid;
        logic [ADDR_W-1:0] addr;
        logic [SNAP_W-1:0] snap;
    } t_branch;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        results_seen = 0;
    int        stall_run = 0;
    int        req_count [0:(1<<REQ_W)-1];
    bit        steady = 1'b0;

    t_in_word          issued_words [$];
    t_branch           branch_pool  [$];
    logic [ADDR_W-1:0] hot_addrs    [0:15];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    gshare_branch_predictor_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    gshare_branch_predictor_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 99) < 70)
            return hot_addrs[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side stall pattern
    always @(posedge clk) begin
        int n;
        if (stall_run > 0) begin
            stall_run--;
        end else if (out_stall || steady) begin
            out_stall <= 1'b0;
            stall_run = $urandom_range(0, 20);
        end else begin
            n = idle_len();
            if (n > 0) begin
                out_stall <= 1'b1;
                stall_run = n - 1;
            end else begin
                stall_run = $urandom_range(0, 8);
            end
        end
    end

    // remember returned snapshots so later updates and squashes use real ones
    always @(posedge clk) begin
        t_in_word src;
        t_branch  b;
        if (rst_n) begin
            if (in_valid && !in_stall)
                issued_words.push_back(in_word);
            if (out_valid && !out_stall && issued_words.size() > 0) begin
                src = issued_words.pop_front();
                results_seen++;
                if (src.req_type == REQ_LOOKUP || src.req_type == REQ_UNCOND) begin
                    b.tid  = src.thread_id;
                    b.addr = src.br_pc;
                    b.snap = out_word.history_snapshot;
                    branch_pool.push_back(b);
                    if (branch_pool.size() > POOL_DEPTH)
                        void'(branch_pool.pop_front());
                end
            end
        end
    end

    task automatic issue(input logic [REQ_W-1:0] req, input logic [TID_W-1:0] tid,
                         input logic [ADDR_W-1:0] addr, input logic tk, input logic sq,
                         input logic [SNAP_W-1:0] snap);
        int gap;
        bit acc;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_word.req_type      <= req;
        in_word.thread_id     <= tid;
        in_word.br_pc         <= addr;
        in_word.taken         <= tk;
        in_word.squashed      <= sq;
        in_word.saved_history <= snap;
        do begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
        end while (!acc);
        req_count[req]++;
    endtask

    initial begin
        int      r;
        int      k;
        bit      tk;
        t_branch b;

        for (int i = 0; i < (1 << REQ_W); i++)
            req_count[i] = 0;
        for (int i = 0; i < 16; i++)
            hot_addrs[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every request kind, saturation at both ends
        issue(REQ_LOOKUP, 0, '0, 1'b0, 1'b0, '0);
        issue(REQ_UNCOND, 1, '1, 1'b1, 1'b1, '1);
        issue(REQ_BTB_FIX, 1, '1, 1'b1, 1'b1, '1);
        issue(REQ_LOOKUP, 1, 32'h5, 1'b0, 1'b0, '0);
        repeat (5)
            issue(REQ_UPDATE, 0, 32'h5, 1'b1, 1'b0, '0);
        issue(REQ_SQUASH, 0, '0, 1'b0, 1'b0, '0);
        issue(REQ_LOOKUP, 0, 32'h5, 1'b0, 1'b0, '0);
        repeat (4)
            issue(REQ_UPDATE, 0, 32'h5, 1'b0, 1'b0, '0);
        issue(REQ_UPDATE, 2, '1, 1'b1, 1'b1, '1);
        issue(REQ_LOOKUP, 2, '1, 1'b0, 1'b0, '0);
        issue(REQ_SQUASH, 3, '0, 1'b1, 1'b1, '1);
        issue(REQ_LOOKUP, 3, 32'hFFFF_F000, 1'b1, 1'b1, '1);
        issue(REQ_UPDATE, 3, 32'h8000_0000, 1'b0, 1'b1, 12'hA5A);
        issue(REQ_BTB_FIX, 3, '0, 1'b0, 1'b0, '0);
        issue(REQ_UNCOND, 3, '0, 1'b0, 1'b0, '0);
        for (int q = REQ_SQUASH + 1; q < (1 << REQ_W); q++)
            issue(REQ_W'(q), TID_W'($urandom), $urandom, 1'($urandom), 1'($urandom),
                  SNAP_W'($urandom));

        // random: mostly lookups and updates, with real snapshots fed back as updates
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = ((n / 100) % 3) == 1;
            r = $urandom_range(0, 99);
            if (r < 38) begin
                issue(REQ_LOOKUP, TID_W'($urandom), pick_addr(), 1'($urandom),
                      1'($urandom), SNAP_W'($urandom));
            end else if (r < 46) begin
                issue(REQ_UNCOND, TID_W'($urandom), pick_addr(), 1'($urandom),
                      1'($urandom), SNAP_W'($urandom));
            end else if (r < 52) begin
                issue(REQ_BTB_FIX, TID_W'($urandom), $urandom, 1'($urandom),
                      1'($urandom), SNAP_W'($urandom));
            end else if (r < 84) begin
                if (branch_pool.size() > 0) begin
                    k  = $urandom_range(0, branch_pool.size() - 1);
                    b  = branch_pool[k];
                    // bias outcome per address so counters train toward both ends
                    tk = $urandom_range(0, 99) < (b.addr[0] ? 85 : 15);
                    issue(REQ_UPDATE, b.tid, b.addr, tk, $urandom_range(0, 99) < 20, b.snap);
                    if ($urandom_range(0, 1))
                        branch_pool.delete(k);
                end else begin
                    issue(REQ_UPDATE, TID_W'($urandom), pick_addr(), 1'($urandom),
                          1'($urandom), SNAP_W'($urandom));
                end
            end else if (r < 92) begin
                if (branch_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
                    b = branch_pool[$urandom_range(0, branch_pool.size() - 1)];
                    issue(REQ_SQUASH, b.tid, $urandom, 1'($urandom), 1'($urandom), b.snap);
                end else begin
                    issue(REQ_SQUASH, TID_W'($urandom), $urandom, 1'($urandom),
                          1'($urandom), SNAP_W'($urandom));
                end
            end else if (r < 96) begin
                issue(REQ_W'($urandom_range(REQ_SQUASH + 1, (1 << REQ_W) - 1)),
                      TID_W'($urandom), $urandom, 1'($urandom), 1'($urandom),
                      SNAP_W'($urandom));
            end else begin
                issue(REQ_W'($urandom_range(REQ_LOOKUP, REQ_SQUASH)), TID_W'($urandom),
                      $urandom, 1'($urandom), 1'($urandom), SNAP_W'($urandom));
            end
        end

        in_valid <= 1'b0;
        steady = 1'b1;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        $display("requests sent: %0d lookup, %0d unconditional, %0d btb fix, %0d update, %0d squash",
                 req_count[REQ_LOOKUP], req_count[REQ_UNCOND], req_count[REQ_BTB_FIX],
                 req_count[REQ_UPDATE], req_count[REQ_SQUASH]);
        $display("%0d unknown request words, %0d result words returned over %0d threads",
                 req_count[5] + req_count[6] + req_count[7], results_seen, THREADS_DEF);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/gbp_pkg.sv
rtl/gbp_ram.sv
rtl/gbp_hist.sv
rtl/gshare_branch_predictor_top.sv
tb/gshare_branch_predictor_checker.sv
tb/gshare_branch_predictor_top_tb.sv
